[src/altitude_thrust_controller_macros.svh]
// assertion macros for the altitude thrust controller checks
`ifndef ALTITUDE_THRUST_CONTROLLER_MACROS_SVH
`define ALTITUDE_THRUST_CONTROLLER_MACROS_SVH

// same-cycle implication, held off during reset
`define ATC_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("altitude thrust controller check failed");

// next-cycle implication, held off during reset
`define ATC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("altitude thrust controller check failed");

// next-cycle implication that also runs while reset is asserted
`define ATC_ASSERT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("altitude thrust controller reset check failed");

`endif

[src/atc_pkg.sv]
// shared widths, codes, types and helpers of the altitude thrust controller
`default_nettype none

package atc_pkg;

  // field widths
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CFG_W     = 23;
  localparam int unsigned TILT_W    = 18;
  localparam int unsigned DT_W      = 17;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned FRAC_W    = 16;

  // shared arithmetic unit widths
  localparam int unsigned ALU_W     = 35;
  localparam int unsigned MUL_A_W   = 24;
  localparam int unsigned RAW_W     = MUL_A_W + DATA_W;
  localparam int unsigned SAT_SRC_W = RAW_W - FRAC_W;

  // divider: magnitude of mass times acceleration, two quotient bits per cycle
  localparam int unsigned DIV_W      = 54;
  localparam int unsigned DIV_CYCLES = DIV_W / 2;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_CYCLES);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POS_GAIN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VEL_GAIN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ASCENT_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DESCENT_LIMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_VEHICLE_MASS  = 3'd5;

  // register reset values
  localparam logic [CFG_W-1:0] GAIN_RST  = 23'd0;
  localparam logic [CFG_W-1:0] LIMIT_RST = 23'd6553600;
  localparam logic [CFG_W-1:0] MASS_RST  = 23'd65536;

  // 9.81 m/s^2 in q16.16
  localparam logic signed [ALU_W-1:0] GRAVITY_Q16 = 35'sd642908;

  localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7fffffff;
  localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh80000000;

  // shared unit operations
  typedef logic [1:0] alu_op_t;
  localparam alu_op_t ALU_ADD = 2'd0;
  localparam alu_op_t ALU_SUB = 2'd1;
  localparam alu_op_t ALU_MUL = 2'd2;

  typedef struct packed {
    alu_op_t                  op;
    logic signed [ALU_W-1:0]  a;
    logic signed [ALU_W-1:0]  b;
  } alu_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [DATA_W-1:0] quot;
  } div_rsp_t;

  // clamp a 40-bit value to the signed 32-bit range
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_SRC_W-1:0] x);
    logic [SAT_SRC_W-DATA_W:0] hi_bits;
    hi_bits = x[SAT_SRC_W-1:DATA_W-1];
    if (hi_bits == '0 || hi_bits == '1) begin
      return x[DATA_W-1:0];
    end else if (x[SAT_SRC_W-1]) begin
      return SAT_MIN;
    end else begin
      return SAT_MAX;
    end
  endfunction

endpackage

`default_nettype wire

[src/atc_if.sv]
// valid/ready channel interfaces of the altitude thrust controller
`default_nettype none

interface atc_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [atc_pkg::DATA_W-1:0] target_height;
  logic signed [atc_pkg::DATA_W-1:0] target_climb;
  logic signed [atc_pkg::DATA_W-1:0] measured_height;
  logic signed [atc_pkg::DATA_W-1:0] measured_climb;
  logic signed [atc_pkg::DATA_W-1:0] accel_feedforward;
  logic signed [atc_pkg::TILT_W-1:0] tilt_cosine;
  logic        [atc_pkg::DT_W-1:0]   time_step;

  modport source (
    output valid, target_height, target_climb, measured_height, measured_climb,
    output accel_feedforward, tilt_cosine, time_step,
    input  ready
  );
  modport sink (
    input  valid, target_height, target_climb, measured_height, measured_climb,
    input  accel_feedforward, tilt_cosine, time_step,
    output ready
  );
endinterface

interface atc_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [atc_pkg::DATA_W-1:0] thrust;
  logic                              divide_fault;

  modport source (output valid, thrust, divide_fault, input ready);
  modport sink (input valid, thrust, divide_fault, output ready);
endinterface

`default_nettype wire

[src/atc_alu.sv]
// shared add/subtract/multiply unit with q16.16 scaling and saturation
`default_nettype none

module atc_alu (
  input  logic                                clk,
  input  atc_pkg::alu_req_t                   req,
  output logic signed [atc_pkg::RAW_W-1:0]    raw_r,
  output logic signed [atc_pkg::DATA_W-1:0]   sat_r
);

  localparam int unsigned SUM_W = atc_pkg::ALU_W + 1;

  logic signed [atc_pkg::MUL_A_W-1:0]   mul_a;
  logic signed [atc_pkg::DATA_W-1:0]    mul_b;
  logic signed [atc_pkg::RAW_W-1:0]     prod;
  logic signed [SUM_W-1:0]              sum;
  logic signed [atc_pkg::RAW_W-1:0]     raw_nxt;
  logic signed [atc_pkg::SAT_SRC_W-1:0] sat_src;

  // signed 24 x 32 product, exact
  assign mul_a = req.a[atc_pkg::MUL_A_W-1:0];
  assign mul_b = req.b[atc_pkg::DATA_W-1:0];
  assign prod  = atc_pkg::RAW_W'(mul_a) * atc_pkg::RAW_W'(mul_b);

  // exact sum or difference, then pick what gets saturated
  always_comb begin
    case (req.op)
      atc_pkg::ALU_ADD: sum = SUM_W'(req.a) + SUM_W'(req.b);
      atc_pkg::ALU_SUB: sum = SUM_W'(req.a) - SUM_W'(req.b);
      default:          sum = '0;
    endcase
    if (req.op == atc_pkg::ALU_MUL) begin
      raw_nxt = prod;
      // arithmetic drop of the fraction bits rounds toward minus infinity
      sat_src = prod[atc_pkg::RAW_W-1:atc_pkg::FRAC_W];
    end else begin
      raw_nxt = atc_pkg::RAW_W'(sum);
      sat_src = atc_pkg::SAT_SRC_W'(sum);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    raw_r <= raw_nxt;
    sat_r <= atc_pkg::sat32(sat_src);
  end

endmodule

`default_nettype wire

[src/atc_div.sv]
// radix-4 restoring divider, truncating toward zero, saturated to 32 bits
`default_nettype none

module atc_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [atc_pkg::RAW_W-1:0]    dividend,
  input  logic signed [atc_pkg::TILT_W-1:0]   divisor,
  output atc_pkg::div_rsp_t                   rsp
);

  localparam logic [atc_pkg::DIV_W-1:0] POS_MAG_MAX = atc_pkg::DIV_W'(atc_pkg::SAT_MAX);
  localparam logic [atc_pkg::DIV_W-1:0] NEG_MAG_MAX = POS_MAG_MAX + atc_pkg::DIV_W'(1);

  logic [atc_pkg::DIV_W-1:0]     mag_r, mag1, mag_nxt;
  logic [atc_pkg::TILT_W-1:0]    rem_r, rem1, rem_nxt, dvs_r;
  logic [atc_pkg::TILT_W:0]      trial1, trial2;
  logic                          q1, q2;
  logic                          neg_r, busy_r, done_r;
  logic [atc_pkg::DIV_CNT_W-1:0] cnt_r;
  logic signed [atc_pkg::DATA_W-1:0] quot_r, quot_nxt;
  logic [atc_pkg::RAW_W-1:0]     dvd_abs;
  logic [atc_pkg::TILT_W-1:0]    dvs_abs;

  // operand magnitudes
  assign dvd_abs = dividend[atc_pkg::RAW_W-1] ? atc_pkg::RAW_W'(-dividend)
                                              : atc_pkg::RAW_W'(dividend);
  assign dvs_abs = divisor[atc_pkg::TILT_W-1] ? atc_pkg::TILT_W'(-divisor)
                                              : atc_pkg::TILT_W'(divisor);

  // two shift-subtract steps per cycle, quotient bits shift into the low end
  always_comb begin
    trial1  = {rem_r, mag_r[atc_pkg::DIV_W-1]};
    q1      = trial1 >= {1'b0, dvs_r};
    rem1    = q1 ? atc_pkg::TILT_W'(trial1 - {1'b0, dvs_r}) : trial1[atc_pkg::TILT_W-1:0];
    mag1    = {mag_r[atc_pkg::DIV_W-2:0], q1};
    trial2  = {rem1, mag1[atc_pkg::DIV_W-1]};
    q2      = trial2 >= {1'b0, dvs_r};
    rem_nxt = q2 ? atc_pkg::TILT_W'(trial2 - {1'b0, dvs_r}) : trial2[atc_pkg::TILT_W-1:0];
    mag_nxt = {mag1[atc_pkg::DIV_W-2:0], q2};
  end

  // apply sign and saturate the final quotient
  always_comb begin
    if (neg_r) begin
      if (mag_nxt > NEG_MAG_MAX) begin
        quot_nxt = atc_pkg::SAT_MIN;
      end else begin
        quot_nxt = -$signed(mag_nxt[atc_pkg::DATA_W-1:0]);
      end
    end else begin
      if (mag_nxt > POS_MAG_MAX) begin
        quot_nxt = atc_pkg::SAT_MAX;
      end else begin
        quot_nxt = $signed(mag_nxt[atc_pkg::DATA_W-1:0]);
      end
    end
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= atc_pkg::DIV_CNT_W'(atc_pkg::DIV_CYCLES - 1);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      mag_r <= dvd_abs[atc_pkg::DIV_W-1:0];
      rem_r <= '0;
      dvs_r <= dvs_abs;
      neg_r <= dividend[atc_pkg::RAW_W-1] ^ divisor[atc_pkg::TILT_W-1];
    end else if (busy_r) begin
      mag_r <= mag_nxt;
      rem_r <= rem_nxt;
      if (cnt_r == '0) begin
        quot_r <= quot_nxt;
      end
    end
  end

  assign rsp = '{done: done_r, quot: quot_r};

endmodule

`default_nettype wire

[src/altitude_thrust_controller.sv]
// altitude thrust controller top level: sequencer, registers and output stage
//
//   channel  | direction | handshake          | payload
//   in_ch    | in        | valid / ready      | targets, measurements, feed-forward, tilt, dt
//   out_ch   | out       | valid / ready      | thrust, divide_fault
//   cfg_*    | in        | cfg_we, no wait    | cfg_idx, cfg_wdata
//
// a transaction runs from acceptance to the result register through 12 steps
// in the shared add/multiply unit, a step that starts the radix-4 divider,
// the division itself and a load of the result.
// in_ch.ready is high only while idle; a waiting result stalls the load.
// reset is synchronous, active low; clears the integrator, presets config registers.
`default_nettype none

module altitude_thrust_controller (
  input  logic                              clk,
  input  logic                              rst_n,
  atc_in_if.sink                            in_ch,
  atc_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [atc_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [atc_pkg::CFG_W-1:0]         cfg_wdata
);

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ERR   = 4'd1;
  localparam logic [3:0] S_POS   = 4'd2;
  localparam logic [3:0] S_VCMD  = 4'd3;
  localparam logic [3:0] S_IMUL  = 4'd4;
  localparam logic [3:0] S_IADD  = 4'd5;
  localparam logic [3:0] S_IGAIN = 4'd6;
  localparam logic [3:0] S_FFADD = 4'd7;
  localparam logic [3:0] S_VERR  = 4'd8;
  localparam logic [3:0] S_VGAIN = 4'd9;
  localparam logic [3:0] S_ACC   = 4'd10;
  localparam logic [3:0] S_DIFF  = 4'd11;
  localparam logic [3:0] S_MASS  = 4'd12;
  localparam logic [3:0] S_DIVGO = 4'd13;
  localparam logic [3:0] S_DIV   = 4'd14;

  localparam int unsigned AW = atc_pkg::ALU_W;
  localparam int unsigned DW = atc_pkg::DATA_W;

  logic [3:0] state_r, state_nxt;

  // configuration registers
  logic [atc_pkg::CFG_W-1:0] pos_gain_r, integral_gain_r, vel_gain_r;
  logic [atc_pkg::CFG_W-1:0] ascent_limit_r, descent_limit_r, vehicle_mass_r;

  // latched input transaction
  logic signed [DW-1:0]              th_r, tc_r, mh_r, mc_r, ff_r;
  logic signed [atc_pkg::TILT_W-1:0] tilt_r;
  logic [atc_pkg::DT_W-1:0]          dt_r;

  // intermediate values
  logic signed [DW-1:0] err_r, vcmd_r, integ_r;
  logic signed [AW-1:0] acc_r;

  // output stage
  logic                 out_valid_r;
  logic signed [DW-1:0] thrust_r;
  logic                 fault_r;

  atc_pkg::alu_req_t            alu_req;
  logic signed [atc_pkg::RAW_W-1:0] alu_raw;
  logic signed [DW-1:0]         alu_sat;
  atc_pkg::div_rsp_t            div_rsp;

  logic                 in_accept;
  logic                 load_out;
  logic signed [DW:0]   v_ext, lo_ext, hi_ext;
  logic signed [DW-1:0] vclamp;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign load_out    = (state_r == S_DIV) && div_rsp.done && (!out_valid_r || out_ch.ready);

  // shared arithmetic unit and divider
  atc_alu u_alu (
    .clk   (clk),
    .req   (alu_req),
    .raw_r (alu_raw),
    .sat_r (alu_sat)
  );

  atc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == S_DIVGO),
    .dividend (alu_raw),
    .divisor  (tilt_r),
    .rsp      (div_rsp)
  );

  // climb command clamp to [-ascent, descent]
  always_comb begin
    v_ext  = {alu_sat[DW-1], alu_sat};
    lo_ext = -$signed((DW + 1)'(ascent_limit_r));
    hi_ext = $signed((DW + 1)'(descent_limit_r));
    if (v_ext < lo_ext) begin
      vclamp = lo_ext[DW-1:0];
    end else if (v_ext > hi_ext) begin
      vclamp = hi_ext[DW-1:0];
    end else begin
      vclamp = alu_sat;
    end
  end

  // operation issued in each step; alu_sat holds the previous step's result
  always_comb begin
    alu_req = '{op: atc_pkg::ALU_ADD, a: '0, b: '0};
    case (state_r)
      S_ERR:   alu_req = '{op: atc_pkg::ALU_SUB, a: AW'(th_r), b: AW'(mh_r)};
      S_POS:   alu_req = '{op: atc_pkg::ALU_MUL, a: AW'(pos_gain_r), b: AW'(alu_sat)};
      S_VCMD:  alu_req = '{op: atc_pkg::ALU_ADD, a: AW'(tc_r), b: AW'(alu_sat)};
      S_IMUL:  alu_req = '{op: atc_pkg::ALU_MUL, a: AW'(dt_r), b: AW'(err_r)};
      S_IADD:  alu_req = '{op: atc_pkg::ALU_ADD, a: AW'(integ_r), b: AW'(alu_sat)};
      S_IGAIN: alu_req = '{op: atc_pkg::ALU_MUL, a: AW'(integral_gain_r), b: AW'(alu_sat)};
      S_FFADD: alu_req = '{op: atc_pkg::ALU_ADD, a: AW'(ff_r), b: AW'(alu_sat)};
      S_VERR:  alu_req = '{op: atc_pkg::ALU_SUB, a: AW'(vcmd_r), b: AW'(mc_r)};
      S_VGAIN: alu_req = '{op: atc_pkg::ALU_MUL, a: AW'(vel_gain_r), b: AW'(alu_sat)};
      S_ACC:   alu_req = '{op: atc_pkg::ALU_ADD, a: acc_r, b: AW'(alu_sat)};
      S_DIFF:  alu_req = '{op: atc_pkg::ALU_SUB, a: atc_pkg::GRAVITY_Q16, b: AW'(alu_sat)};
      S_MASS:  alu_req = '{op: atc_pkg::ALU_MUL, a: AW'(vehicle_mass_r), b: AW'(alu_sat)};
      default: alu_req = '{op: atc_pkg::ALU_ADD, a: '0, b: '0};
    endcase
  end

  // step sequence
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_accept) state_nxt = S_ERR;
      S_ERR:   state_nxt = S_POS;
      S_POS:   state_nxt = S_VCMD;
      S_VCMD:  state_nxt = S_IMUL;
      S_IMUL:  state_nxt = S_IADD;
      S_IADD:  state_nxt = S_IGAIN;
      S_IGAIN: state_nxt = S_FFADD;
      S_FFADD: state_nxt = S_VERR;
      S_VERR:  state_nxt = S_VGAIN;
      S_VGAIN: state_nxt = S_ACC;
      S_ACC:   state_nxt = S_DIFF;
      S_DIFF:  state_nxt = S_MASS;
      S_MASS:  state_nxt = S_DIVGO;
      S_DIVGO: state_nxt = S_DIV;
      S_DIV:   if (load_out) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state, configuration and integrator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      out_valid_r     <= 1'b0;
      integ_r         <= '0;
      pos_gain_r      <= atc_pkg::GAIN_RST;
      integral_gain_r <= atc_pkg::GAIN_RST;
      vel_gain_r      <= atc_pkg::GAIN_RST;
      ascent_limit_r  <= atc_pkg::LIMIT_RST;
      descent_limit_r <= atc_pkg::LIMIT_RST;
      vehicle_mass_r  <= atc_pkg::MASS_RST;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_IGAIN) begin
        integ_r <= alu_sat;
      end
      if (cfg_we) begin
        case (cfg_idx)
          atc_pkg::CFG_POS_GAIN:      pos_gain_r      <= cfg_wdata;
          atc_pkg::CFG_INTEGRAL_GAIN: integral_gain_r <= cfg_wdata;
          atc_pkg::CFG_VEL_GAIN:      vel_gain_r      <= cfg_wdata;
          atc_pkg::CFG_ASCENT_LIMIT:  ascent_limit_r  <= cfg_wdata;
          atc_pkg::CFG_DESCENT_LIMIT: descent_limit_r <= cfg_wdata;
          atc_pkg::CFG_VEHICLE_MASS:  vehicle_mass_r  <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // input latch, intermediate captures and result register
  always_ff @(posedge clk) begin
    if (in_accept) begin
      th_r   <= in_ch.target_height;
      tc_r   <= in_ch.target_climb;
      mh_r   <= in_ch.measured_height;
      mc_r   <= in_ch.measured_climb;
      ff_r   <= in_ch.accel_feedforward;
      tilt_r <= in_ch.tilt_cosine;
      dt_r   <= in_ch.time_step;
    end
    if (state_r == S_POS) begin
      err_r <= alu_sat;
    end
    if (state_r == S_IMUL) begin
      vcmd_r <= vclamp;
    end
    // feed-forward plus integral term stays unsaturated until the last add
    if (state_r == S_VERR) begin
      acc_r <= alu_raw[AW-1:0];
    end
    if (load_out) begin
      fault_r  <= (tilt_r == '0);
      thrust_r <= (tilt_r == '0) ? atc_pkg::SAT_MAX : div_rsp.quot;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.thrust       = thrust_r;
  assign out_ch.divide_fault = fault_r;

endmodule

`default_nettype wire

[src/atc_checker.sv]
// port-level checks of the altitude thrust controller, bound to the top level
`default_nettype none
`include "altitude_thrust_controller_macros.svh"

module atc_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [atc_pkg::DATA_W-1:0]  thrust,
  input logic                        divide_fault
);

  // reset leaves no result pending and the input open
  `ATC_ASSERT_RST(a_reset_idle, !rst_n, !out_valid && in_ready)

  // one transaction at a time: input closes right after acceptance
  `ATC_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

  // a zero tilt cosine always reports the largest thrust
  `ATC_ASSERT(a_fault_max_thrust, out_valid && divide_fault, thrust == atc_pkg::SAT_MAX)

  // a stalled result holds
  `ATC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(thrust) && $stable(divide_fault))

endmodule

bind altitude_thrust_controller atc_checker u_atc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .thrust       (out_ch.thrust),
  .divide_fault (out_ch.divide_fault)
);

`default_nettype wire
